### rtl/h264_depkt_pkg.sv
// Package: shared types and constants for the H.264 RTP depacketizer.
`timescale 1ns / 1ps
package h264_depkt_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_SINGLE  = 3'd1,
      MODE_STAP    = 3'd2,
      MODE_FU_HDR  = 3'd3,
      MODE_FU_DATA = 3'd4,
      MODE_SWALLOW = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      PH_HIGH  = 2'd0,
      PH_LOW   = 2'd1,
      PH_FIRST = 2'd2,
      PH_BODY  = 2'd3
   } phase_type;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_HEADER    = 3'd1;
   localparam logic [2:0] ERR_TYPE      = 3'd2;
   localparam logic [2:0] ERR_FU_SHORT  = 3'd3;
   localparam logic [2:0] ERR_FU_HDR    = 3'd4;
   localparam logic [2:0] ERR_STAP_LEN  = 3'd5;
   localparam logic [2:0] ERR_STAP_TYPE = 3'd6;
   localparam logic [2:0] ERR_STAP_TAIL = 3'd7;

   localparam logic [1:0] UM_SINGLE = 2'd0;
   localparam logic [1:0] UM_STAP   = 2'd1;
   localparam logic [1:0] UM_FU     = 2'd2;

   localparam logic [4:0] NAL_IDR  = 5'd5;
   localparam logic [4:0] NAL_SPS  = 5'd7;
   localparam logic [4:0] NAL_PPS  = 5'd8;
   localparam logic [4:0] NAL_STAP = 5'd24;
   localparam logic [4:0] NAL_FU_A = 5'd28;
   localparam logic [4:0] NAL_LAST_SINGLE = 5'd23;

   // One result row.
   typedef struct packed {
      logic       result_kind;
      logic [7:0] out_byte;
      logic       unit_first;
      logic       unit_last;
      logic [1:0] unit_mode;
      logic [4:0] nal_kind;
      logic [1:0] fu_flags;
      logic [7:0] rebuilt_header;
      logic [3:0] key_flags;
      logic [1:0] frame_flags;
      logic [2:0] error_code;
      logic       run_last;
   } result_type;

   // Up to two results from one transfer.
   typedef struct packed {
      logic       data_valid;
      logic       stat_valid;
      result_type data_row;
      result_type stat_row;
   } pair_type;

   function automatic logic [3:0] unit_keys(input logic [4:0] t, input logic [31:0] mask);
      logic [3:0] k;
      k    = '0;
      k[0] = (t == NAL_SPS);
      k[1] = (t == NAL_PPS);
      k[2] = (t == NAL_IDR);
      k[3] = mask[t];
      return k;
   endfunction

endpackage

### rtl/h264_depkt_parse.sv
// Parser: per-byte state update and result generation.
`timescale 1ns / 1ps
module h264_depkt_parse
   import h264_depkt_pkg::*;
#(
   parameter int LEN_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  data_byte,
   input  logic        first_byte,
   input  logic        last_byte,
   input  logic        empty_packet,
   input  logic        rtp_marker,
   input  logic        header_ok,
   input  logic [31:0] key_mask,
   output pair_type    pair
);

   mode_type    mode_ff, mode_in;
   phase_type   phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;   // byte index, saturated at 3 (only ==2 matters)
   logic [7:0]  lenh_ff, lenh_in;
   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic [4:0]  type_ff, type_in;
   logic [7:0]  ind_ff, ind_in;
   logic [1:0]  fuh_ff, fuh_in;
   logic [3:0]  agg_ff, agg_in;
   logic        seen_ff, seen_in;
   logic [2:0]  perr_ff, perr_in;

   logic [4:0]  t;
   logic [15:0] len;
   logic [2:0]  err;
   logic [1:0]  ff;
   logic        dv, uf, ul;
   logic [1:0]  um;
   logic [LEN_BITS-1:0] rem_dec;

   assign t       = data_byte[4:0];
   assign len     = {lenh_ff, data_byte};
   assign rem_dec = rem_ff - LEN_BITS'(1);

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      lenh_in  = lenh_ff;
      rem_in   = rem_ff;
      type_in  = type_ff;
      ind_in   = ind_ff;
      fuh_in   = fuh_ff;
      agg_in   = agg_ff;
      seen_in  = seen_ff;
      perr_in  = perr_ff;
      err      = ERR_NONE;
      ff       = {rtp_marker, 1'b0};
      dv       = 1'b0;
      uf       = 1'b0;
      ul       = 1'b0;
      um       = UM_SINGLE;
      pair     = '0;
      if (!step) begin
         // hold
      end else if (empty_packet) begin
         mode_in = MODE_IDLE;
         agg_in  = '0;
         pair.stat_valid          = 1'b1;
         pair.stat_row.result_kind = 1'b1;
         pair.stat_row.error_code  = ERR_HEADER;
         pair.stat_row.run_last    = 1'b1;
      end else if (!first_byte && mode_ff == MODE_IDLE) begin
         // drop stray byte
      end else begin
         if (first_byte) begin
            phase_in = PH_HIGH;
            lenh_in  = '0;
            rem_in   = '0;
            type_in  = '0;
            ind_in   = '0;
            fuh_in   = '0;
            agg_in   = '0;
            seen_in  = 1'b0;
            perr_in  = ERR_NONE;
            if (!header_ok) begin
               err = ERR_HEADER;
            end else if (t >= 5'd1 && t <= NAL_LAST_SINGLE) begin
               mode_in = MODE_SINGLE;
               type_in = t;
               agg_in  = unit_keys(t, key_mask);
               dv = 1'b1; uf = 1'b1; ul = last_byte;
            end else if (t == NAL_STAP) begin
               mode_in = MODE_STAP;
            end else if (t == NAL_FU_A) begin
               mode_in = MODE_FU_HDR;
               ind_in  = data_byte;
            end else begin
               err = ERR_TYPE;
            end
         end else begin
            unique case (mode_ff)
               MODE_SINGLE: begin
                  dv = 1'b1; ul = last_byte;
               end
               MODE_STAP: begin
                  unique case (phase_ff)
                     PH_HIGH: begin
                        lenh_in  = data_byte;
                        phase_in = PH_LOW;
                     end
                     PH_LOW: begin
                        if (len == 16'd0 || (len >> LEN_BITS) != 16'd0) begin
                           err = ERR_STAP_LEN;
                        end else begin
                           rem_in   = len[LEN_BITS-1:0];
                           phase_in = PH_FIRST;
                        end
                     end
                     default: begin
                        if (phase_ff == PH_FIRST && (t == 5'd0 || t >= NAL_STAP)) begin
                           err = ERR_STAP_TYPE;
                        end else begin
                           if (phase_ff == PH_FIRST) begin
                              type_in = t;
                              agg_in  = agg_ff | unit_keys(t, key_mask);
                              seen_in = 1'b1;
                           end
                           rem_in   = rem_dec;
                           dv = 1'b1; um = UM_STAP;
                           uf = (phase_ff == PH_FIRST);
                           ul = (rem_dec == '0);
                           phase_in = (rem_dec == '0) ? PH_HIGH : PH_BODY;
                        end
                     end
                  endcase
               end
               MODE_FU_HDR: begin
                  if (last_byte) begin
                     err = ERR_FU_SHORT;
                  end else if (data_byte[5] || (data_byte[7] && data_byte[6]) ||
                               t == 5'd0 || t >= NAL_STAP) begin
                     err = ERR_FU_HDR;
                  end else begin
                     type_in = t;
                     fuh_in  = {data_byte[6], data_byte[7]};
                     agg_in  = unit_keys(t, key_mask);
                     mode_in = MODE_FU_DATA;
                  end
               end
               MODE_FU_DATA: begin
                  dv = 1'b1; um = UM_FU;
                  uf = (idx_ff == 2'd2); ul = last_byte;
               end
               default: err = perr_ff;
            endcase
         end
         idx_in = first_byte ? 2'd1 : ((idx_ff == 2'd3) ? idx_ff : idx_ff + 2'd1);

         // data row uses the unit type as updated by this byte
         pair.data_valid              = dv;
         pair.data_row.out_byte       = data_byte;
         pair.data_row.unit_first     = uf;
         pair.data_row.unit_last      = ul;
         pair.data_row.unit_mode      = um;
         pair.data_row.nal_kind       = type_in;
         pair.data_row.key_flags      = unit_keys(type_in, key_mask);
         if (um == UM_FU) begin
            pair.data_row.fu_flags       = fuh_ff;
            pair.data_row.rebuilt_header = {ind_ff[7:5], type_ff};
         end
         pair.data_row.run_last = dv && !last_byte && err == ERR_NONE;

         if (err != ERR_NONE) begin
            if (last_byte) begin
               mode_in = MODE_IDLE;
            end else begin
               mode_in = MODE_SWALLOW;
               perr_in = err;
            end
         end else if (last_byte) begin
            if (mode_in == MODE_STAP) begin
               if (phase_in == PH_FIRST || phase_in == PH_BODY) err = ERR_STAP_LEN;
               else if (phase_in == PH_LOW) err = ERR_STAP_TAIL;
               else if (!seen_in) err = ERR_STAP_TAIL;
            end else if (mode_in == MODE_FU_HDR) begin
               err = ERR_FU_SHORT;
            end else if (mode_in == MODE_FU_DATA) begin
               ff = {fuh_in[1] & rtp_marker, fuh_in[0]};
            end
            mode_in = MODE_IDLE;
         end
         if (last_byte) begin
            pair.stat_valid           = 1'b1;
            pair.stat_row.result_kind = 1'b1;
            pair.stat_row.error_code  = err;
            pair.stat_row.key_flags   = (err == ERR_NONE) ? agg_in : 4'd0;
            pair.stat_row.frame_flags = (err == ERR_NONE) ? ff : 2'd0;
            pair.stat_row.run_last    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         phase_ff <= PH_HIGH;
         idx_ff   <= '0;
         lenh_ff  <= '0;
         rem_ff   <= '0;
         type_ff  <= '0;
         ind_ff   <= '0;
         fuh_ff   <= '0;
         agg_ff   <= '0;
         seen_ff  <= 1'b0;
         perr_ff  <= ERR_NONE;
      end else begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         lenh_ff  <= lenh_in;
         rem_ff   <= rem_in;
         type_ff  <= type_in;
         ind_ff   <= ind_in;
         fuh_ff   <= fuh_in;
         agg_ff   <= agg_in;
         seen_ff  <= seen_in;
         perr_ff  <= perr_in;
      end
   end

endmodule

### rtl/h264_depkt_outq.sv
// Output queue: four-entry FIFO of result rows, up to two pushed per cycle.
`timescale 1ns / 1ps
module h264_depkt_outq
   import h264_depkt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  pair_type   pair,
   output logic       room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_row
);

   result_type  mem_ff [4];
   logic [1:0]  rd_ff, rd_in, wr_ff, wr_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        pop;
   logic [1:0]  npush;

   assign out_valid = (cnt_ff != 3'd0);
   assign out_row   = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign npush     = {1'b0, pair.data_valid} + {1'b0, pair.stat_valid};
   // accept only when two slots remain free
   assign room      = (cnt_ff <= 3'd2);

   always_comb begin
      rd_in  = rd_ff + {1'b0, pop};
      wr_in  = wr_ff + npush;
      cnt_in = cnt_ff + {1'b0, npush} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   // write data and status rows
   always_ff @(posedge clock) begin
      if (pair.data_valid) mem_ff[wr_ff] <= pair.data_row;
      if (pair.stat_valid) mem_ff[wr_ff + {1'b0, pair.data_valid}] <= pair.stat_row;
   end

endmodule

### rtl/h264_rtp_payload_depacketizer.sv
// Top level: H.264 RTP payload depacketizer.
`timescale 1ns / 1ps
// Takes one payload byte per transfer and gives NAL unit data bytes plus a
// status row at each packet's last byte. A byte is taken every cycle while the
// four-entry result queue has two free slots; results are registered in the
// queue and leave at one per cycle while rsp_ready is high, so a byte ending
// a packet that also carries data gives two rows. mask_ff is written via csr_.
module h264_rtp_payload_depacketizer
   import h264_depkt_pkg::*;
#(
   parameter int LEN_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic        req_empty_packet,
   input  logic        req_rtp_marker,
   input  logic        req_header_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_unit_first,
   output logic        rsp_unit_last,
   output logic [1:0]  rsp_unit_mode,
   output logic [4:0]  rsp_nal_kind,
   output logic [1:0]  rsp_fu_flags,
   output logic [7:0]  rsp_rebuilt_header,
   output logic [3:0]  rsp_key_flags,
   output logic [1:0]  rsp_frame_flags,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_run_last,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic [31:0] mask_ff;
   pair_type    pair;
   result_type  row;
   logic        room;

   always_ff @(posedge clock) begin
      if (reset) mask_ff <= 32'h0000_01A0;
      else if (csr_write_enable) mask_ff <= csr_write_data;
   end

   assign req_ready = room;

   h264_depkt_parse #(.LEN_BITS(LEN_BITS)) u_parse (
      .clock, .reset,
      .step        (req_valid && room),
      .data_byte   (req_data_byte),
      .first_byte  (req_first_byte),
      .last_byte   (req_last_byte),
      .empty_packet(req_empty_packet),
      .rtp_marker  (req_rtp_marker),
      .header_ok   (req_header_ok),
      .key_mask    (mask_ff),
      .pair
   );

   h264_depkt_outq u_outq (
      .clock, .reset, .pair, .room,
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_row(row)
   );

   assign rsp_result_kind    = row.result_kind;
   assign rsp_out_byte       = row.out_byte;
   assign rsp_unit_first     = row.unit_first;
   assign rsp_unit_last      = row.unit_last;
   assign rsp_unit_mode      = row.unit_mode;
   assign rsp_nal_kind       = row.nal_kind;
   assign rsp_fu_flags       = row.fu_flags;
   assign rsp_rebuilt_header = row.rebuilt_header;
   assign rsp_key_flags      = row.key_flags;
   assign rsp_frame_flags    = row.frame_flags;
   assign rsp_error_code     = row.error_code;
   assign rsp_run_last       = row.run_last;

endmodule

### rtl/h264_depkt_check.sv
// Checker: port-level properties of the depacketizer, bound to the top level.
`timescale 1ns / 1ps
module h264_depkt_check (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_result_kind,
   input logic [2:0] rsp_error_code,
   input logic [3:0] rsp_key_flags,
   input logic [1:0] rsp_frame_flags,
   input logic       rsp_run_last
);

   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // status always ends a run
   a_stat_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_run_last)
      else $error("status without run_last");

   // data carries no error code or frame flags
   a_data_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> rsp_error_code == 3'd0 && rsp_frame_flags == 2'd0)
      else $error("data result with status fields");

   // errored status reports no flags
   a_err_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != 3'd0 |-> rsp_key_flags == 4'd0 && rsp_frame_flags == 2'd0)
      else $error("flags on errored status");

endmodule

bind h264_rtp_payload_depacketizer h264_depkt_check u_check (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_result_kind,
   .rsp_error_code, .rsp_key_flags, .rsp_frame_flags, .rsp_run_last
);
